>>> src/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// shared types and constants of the scanline bar segmenter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bss_pkg;

   localparam int LINE_PIXELS_DEF = 4096;
   localparam int MAX_BARS_DEF    = 63;

   // configuration register indexes
   localparam logic [2:0] REG_LEFT_START  = 3'd0;
   localparam logic [2:0] REG_LEFT_END    = 3'd1;
   localparam logic [2:0] REG_RIGHT_START = 3'd2;
   localparam logic [2:0] REG_RIGHT_END   = 3'd3;
   localparam logic [2:0] REG_WHITE_LEVEL = 3'd4;
   localparam logic [2:0] REG_QUIET_RUN   = 3'd5;

   typedef enum logic [20:0] {
      ST_IDLE        = 21'h000001,
      ST_LS_INIT     = 21'h000002,
      ST_LS_RD       = 21'h000004,
      ST_LS_EVAL     = 21'h000008,
      ST_RS_INIT     = 21'h000010,
      ST_RS_RD       = 21'h000020,
      ST_RS_EVAL     = 21'h000040,
      ST_CHECK       = 21'h000080,
      ST_AV_RD       = 21'h000100,
      ST_AV_ACC      = 21'h000200,
      ST_DIV_INIT    = 21'h000400,
      ST_DIV         = 21'h000800,
      ST_SG_INIT     = 21'h001000,
      ST_SG_RD0      = 21'h002000,
      ST_SG_CUR      = 21'h004000,
      ST_SG_RD       = 21'h008000,
      ST_SG_EVAL     = 21'h010000,
      ST_SG_HOLD     = 21'h020000,
      ST_SUM_LOAD    = 21'h040000,
      ST_SUM_HOLD    = 21'h080000,
      ST_SG_HOLD_END = 21'h100000
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic ls_init;
      logic ls_eval;
      logic rs_init;
      logic rs_eval;
      logic set_err;
      logic av_init;
      logic av_acc;
      logic div_init;
      logic div_step;
      logic sg_init;
      logic sg_cur;
      logic rd_next;
      logic sg_eval;
      logic sum_load;
      logic line_done;
   } cmd_type;

   typedef struct packed {
      logic ls_empty;
      logic rs_empty;
      logic hit;
      logic ls_end;
      logic rs_end;
      logic crossed;
      logic at_right;
      logic div_last;
      logic emit;
      logic out_taken;
   } status_type;

endpackage

>>> src/bss_ram.sv
// ----------------------------------------------------------------------------
// bss_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bss_datapath.sv
// ----------------------------------------------------------------------------
// bss_datapath
// line store, configuration, search, mean and bar segmentation datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bss_datapath import bss_pkg::*; #(
   parameter int LINE_PIXELS = LINE_PIXELS_DEF,
   parameter int MAX_BARS    = MAX_BARS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [7:0]         req_pixel_value,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_result_kind,
   output logic               rsp_bar_is_white,
   output logic [12:0]        rsp_bar_width,
   output logic signed [20:0] rsp_bar_area,
   output logic [11:0]        rsp_found_left_edge,
   output logic [11:0]        rsp_found_right_edge,
   output logic [7:0]         rsp_threshold_average,
   output logic [5:0]         rsp_bar_total,
   output logic               rsp_bars_overflowed,
   output logic               rsp_edge_error,
   output logic               rsp_last_result
);

   localparam int AW = $clog2(LINE_PIXELS);
   localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;

   // configuration
   logic [11:0] cfg_ls_ff, cfg_le_ff, cfg_rs_ff, cfg_re_ff, cfg_quiet_ff;
   logic [7:0]  cfg_white_ff;

   // line store
   logic [AW:0]   load_cnt_ff;
   logic          line_full;
   logic [12:0]   rd_idx;
   logic [CW-1:0] rd_ext;
   logic [CW-1:0] cnt_ext;
   logic          pix_ok_ff;
   logic [7:0]    ram_q;
   logic [7:0]    pix;

   // pass state
   logic [12:0]        idx_ff, white_cnt_ff;
   logic [11:0]        last_black_ff, left_ff, right_ff;
   logic [7:0]         avg_ff, quo_ff, cur_ff;
   logic [20:0]        acc_ff;
   logic [2:0]         bit_ff;
   logic signed [20:0] area_ff;
   logic [12:0]        run_start_ff;
   logic               run_white_ff, ovf_ff, err_ff;
   logic [5:0]         bar_cnt_ff;

   // output register
   logic               o_valid_ff, o_kind_ff, o_white_ff, o_ovf_ff, o_err_ff, o_last_ff;
   logic [12:0]        o_width_ff;
   logic signed [20:0] o_area_ff;
   logic [5:0]         o_total_ff;

   // combinational helpers
   logic               is_white;
   logic [12:0]        white_in;
   logic [11:0]        lb_in;
   logic               hit;
   logic [12:0]        span;
   logic [20:0]        trial;
   logic               fits;
   logic [7:0]         quo_in;
   logic signed [20:0] delta;
   logic signed [20:0] area_in;
   logic               close;
   logic               cap_ok;

   assign line_full = load_cnt_ff == (AW + 1)'(LINE_PIXELS);
   assign rd_idx    = cmd.rd_next ? idx_ff + 13'd1 : idx_ff;
   assign rd_ext    = CW'(rd_idx);
   assign cnt_ext   = CW'(load_cnt_ff);

   bss_ram #(
      .WIDTH (8),
      .DEPTH (LINE_PIXELS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.load && !line_full),
      .wr_addr (load_cnt_ff[AW-1:0]),
      .wr_data (req_pixel_value),
      .rd_addr (rd_ext[AW-1:0]),
      .rd_data (ram_q)
   );

   // pixels past the loaded part of the line read as full white
   assign pix = pix_ok_ff ? ram_q : 8'hFF;

   // edge search step
   assign is_white = pix >= cfg_white_ff;
   assign white_in = is_white ? white_cnt_ff + 13'd1 : 13'd0;
   assign lb_in    = is_white ? last_black_ff : idx_ff[11:0];
   assign hit      = white_in > {1'b0, cfg_quiet_ff};

   // restoring division step
   assign span   = {1'b0, right_ff} - {1'b0, left_ff} + 13'd1;
   assign trial  = 21'(span) << bit_ff;
   assign fits   = acc_ff >= trial;
   assign quo_in = fits ? (quo_ff | (8'd1 << bit_ff)) : quo_ff;

   // segmentation step
   assign delta   = run_white_ff ? 21'(signed'({1'b0, cur_ff}) - signed'({1'b0, avg_ff}))
                                 : 21'(signed'({1'b0, avg_ff}) - signed'({1'b0, cur_ff}));
   assign area_in = area_ff + delta;
   assign close   = run_white_ff ? (pix < avg_ff) : (pix >= avg_ff);
   assign cap_ok  = {26'd0, bar_cnt_ff} < 32'(MAX_BARS);

   always_comb begin
      status           = '0;
      status.ls_empty  = cfg_ls_ff < cfg_le_ff;
      status.rs_empty  = cfg_rs_ff > cfg_re_ff;
      status.hit       = hit;
      status.ls_end    = idx_ff[11:0] == cfg_le_ff;
      status.rs_end    = idx_ff[11:0] == cfg_re_ff;
      status.crossed   = right_ff < left_ff;
      status.at_right  = idx_ff == {1'b0, right_ff};
      status.div_last  = bit_ff == 3'd0;
      status.emit      = close && cap_ok;
      status.out_taken = o_valid_ff && rsp_ready;
   end

   always_ff @(posedge clock) begin
      pix_ok_ff <= rd_ext < cnt_ext;
      if (reset) begin
         cfg_ls_ff    <= 12'd2048;
         cfg_le_ff    <= 12'd0;
         cfg_rs_ff    <= 12'd2048;
         cfg_re_ff    <= 12'd4095;
         cfg_white_ff <= 8'd128;
         cfg_quiet_ff <= 12'd16;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_LEFT_START:  cfg_ls_ff    <= csr_wdata;
            REG_LEFT_END:    cfg_le_ff    <= csr_wdata;
            REG_RIGHT_START: cfg_rs_ff    <= csr_wdata;
            REG_RIGHT_END:   cfg_re_ff    <= csr_wdata;
            REG_WHITE_LEVEL: cfg_white_ff <= csr_wdata[7:0];
            REG_QUIET_RUN:   cfg_quiet_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff  <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         avg_ff       <= '0;
         area_ff      <= '0;
         run_start_ff <= '0;
         run_white_ff <= 1'b0;
         bar_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
         err_ff       <= 1'b0;
         o_valid_ff   <= 1'b0;
      end else begin
         if (cmd.load && !line_full) begin
            load_cnt_ff <= load_cnt_ff + (AW + 1)'(1);
         end
         if (cmd.line_done) begin
            load_cnt_ff <= '0;
         end
         if (cmd.start) begin
            bar_cnt_ff   <= '0;
            area_ff      <= '0;
            run_white_ff <= 1'b0;
            ovf_ff       <= 1'b0;
            err_ff       <= 1'b0;
         end
         if (cmd.ls_init && status.ls_empty) begin
            left_ff <= '0;
         end
         if (cmd.ls_eval) begin
            if (hit) begin
               left_ff <= lb_in;
            end else if (status.ls_end) begin
               left_ff <= '0;
            end
         end
         if (cmd.rs_init && status.rs_empty) begin
            right_ff <= '0;
         end
         if (cmd.rs_eval) begin
            if (hit) begin
               right_ff <= lb_in;
            end else if (status.rs_end) begin
               right_ff <= '0;
            end
         end
         if (cmd.set_err) begin
            err_ff <= 1'b1;
            avg_ff <= '0;
         end
         if (cmd.div_step && status.div_last) begin
            avg_ff <= quo_in;
         end
         if (cmd.sg_init) begin
            run_start_ff <= {1'b0, left_ff};
         end
         if (cmd.sg_eval) begin
            if (close) begin
               area_ff      <= '0;
               run_white_ff <= !run_white_ff;
               run_start_ff <= idx_ff + 13'd1;
               if (cap_ok) begin
                  bar_cnt_ff <= bar_cnt_ff + 6'd1;
               end else begin
                  ovf_ff <= 1'b1;
               end
            end else begin
               area_ff <= area_in;
            end
         end
         // output register
         if (status.out_taken) begin
            o_valid_ff <= 1'b0;
         end
         if ((cmd.sg_eval && status.emit) || cmd.sum_load) begin
            o_valid_ff <= 1'b1;
         end
      end
   end

   // pass registers without reset
   always_ff @(posedge clock) begin
      if (cmd.ls_init) begin
         idx_ff        <= {1'b0, cfg_ls_ff};
         white_cnt_ff  <= '0;
         last_black_ff <= cfg_ls_ff;
      end
      if (cmd.rs_init) begin
         idx_ff        <= {1'b0, cfg_rs_ff};
         white_cnt_ff  <= '0;
         last_black_ff <= cfg_rs_ff;
      end
      if (cmd.ls_eval || cmd.rs_eval) begin
         white_cnt_ff  <= white_in;
         last_black_ff <= lb_in;
         if (cmd.ls_eval) begin
            idx_ff <= idx_ff - 13'd1;
         end else begin
            idx_ff <= idx_ff + 13'd1;
         end
      end
      if (cmd.av_init) begin
         idx_ff <= {1'b0, left_ff};
         acc_ff <= '0;
      end
      if (cmd.av_acc) begin
         acc_ff <= acc_ff + 21'(pix);
         if (!status.at_right) begin
            idx_ff <= idx_ff + 13'd1;
         end
      end
      if (cmd.div_init) begin
         quo_ff <= '0;
         bit_ff <= 3'd7;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
         bit_ff <= bit_ff - 3'd1;
         if (fits) begin
            acc_ff <= acc_ff - trial;
         end
      end
      if (cmd.sg_init) begin
         idx_ff <= {1'b0, left_ff};
      end
      if (cmd.sg_cur) begin
         cur_ff <= pix;
      end
      if (cmd.sg_eval && !status.at_right) begin
         idx_ff <= idx_ff + 13'd1;
         cur_ff <= pix;
      end
      if (cmd.sg_eval && status.emit) begin
         o_kind_ff  <= 1'b0;
         o_white_ff <= run_white_ff;
         o_width_ff <= idx_ff + 13'd1 - run_start_ff;
         o_area_ff  <= area_in;
         o_total_ff <= '0;
         o_ovf_ff   <= 1'b0;
         o_err_ff   <= 1'b0;
         o_last_ff  <= 1'b0;
      end
      if (cmd.sum_load) begin
         o_kind_ff  <= 1'b1;
         o_white_ff <= 1'b0;
         o_width_ff <= '0;
         o_area_ff  <= '0;
         o_total_ff <= bar_cnt_ff;
         o_ovf_ff   <= ovf_ff;
         o_err_ff   <= err_ff;
         o_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid             = o_valid_ff;
   assign rsp_result_kind       = o_kind_ff;
   assign rsp_bar_is_white      = o_white_ff;
   assign rsp_bar_width         = o_width_ff;
   assign rsp_bar_area          = o_area_ff;
   assign rsp_found_left_edge   = left_ff;
   assign rsp_found_right_edge  = right_ff;
   assign rsp_threshold_average = avg_ff;
   assign rsp_bar_total         = o_total_ff;
   assign rsp_bars_overflowed   = o_ovf_ff;
   assign rsp_edge_error        = o_err_ff;
   assign rsp_last_result       = o_last_ff;

endmodule

>>> src/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl
// sequencer for loading and the search, mean and segmentation passes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bss_ctrl import bss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_line_end,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_line_end) begin
                  cmd.start = 1'b1;
                  state_in  = ST_LS_INIT;
               end
            end
         end
         ST_LS_INIT: begin
            cmd.ls_init = 1'b1;
            state_in    = status.ls_empty ? ST_RS_INIT : ST_LS_RD;
         end
         ST_LS_RD: state_in = ST_LS_EVAL;
         ST_LS_EVAL: begin
            cmd.ls_eval = 1'b1;
            state_in    = (status.hit || status.ls_end) ? ST_RS_INIT : ST_LS_RD;
         end
         ST_RS_INIT: begin
            cmd.rs_init = 1'b1;
            state_in    = status.rs_empty ? ST_CHECK : ST_RS_RD;
         end
         ST_RS_RD: state_in = ST_RS_EVAL;
         ST_RS_EVAL: begin
            cmd.rs_eval = 1'b1;
            state_in    = (status.hit || status.rs_end) ? ST_CHECK : ST_RS_RD;
         end
         ST_CHECK: begin
            if (status.crossed) begin
               cmd.set_err = 1'b1;
               state_in    = ST_SUM_LOAD;
            end else begin
               cmd.av_init = 1'b1;
               state_in    = ST_AV_RD;
            end
         end
         ST_AV_RD: state_in = ST_AV_ACC;
         ST_AV_ACC: begin
            cmd.av_acc = 1'b1;
            state_in   = status.at_right ? ST_DIV_INIT : ST_AV_RD;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SG_INIT;
            end
         end
         ST_SG_INIT: begin
            cmd.sg_init = 1'b1;
            state_in    = ST_SG_RD0;
         end
         ST_SG_RD0: state_in = ST_SG_CUR;
         ST_SG_CUR: begin
            cmd.sg_cur = 1'b1;
            state_in   = ST_SG_RD;
         end
         ST_SG_RD: begin
            cmd.rd_next = 1'b1;
            state_in    = ST_SG_EVAL;
         end
         ST_SG_EVAL: begin
            cmd.sg_eval = 1'b1;
            if (status.emit) begin
               // the index moves on during the eval, so remember the span end here
               state_in = status.at_right ? ST_SG_HOLD_END : ST_SG_HOLD;
            end else begin
               state_in = status.at_right ? ST_SUM_LOAD : ST_SG_RD;
            end
         end
         ST_SG_HOLD: begin
            if (status.out_taken) begin
               state_in = ST_SG_RD;
            end
         end
         ST_SG_HOLD_END: begin
            if (status.out_taken) begin
               state_in = ST_SUM_LOAD;
            end
         end
         ST_SUM_LOAD: begin
            cmd.sum_load = 1'b1;
            state_in     = ST_SUM_HOLD;
         end
         ST_SUM_HOLD: begin
            if (status.out_taken) begin
               cmd.line_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> src/barcode_scanline_bar_segmenter_core.sv
// ----------------------------------------------------------------------------
// barcode_scanline_bar_segmenter_core
// pixel requests without line_end are taken one per cycle while idle; a line_end
// request runs each edge search and the mean with a read and a step state per
// pixel, then the 8-step divider, then segmentation with a read and an eval
// state per span pixel plus output wait; the single line ram read port is why
// pixels need read states; synchronous active-high reset, line ram not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barcode_scanline_bar_segmenter_core import bss_pkg::*; #(
   parameter int LINE_PIXELS = LINE_PIXELS_DEF,
   parameter int MAX_BARS    = MAX_BARS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // pixel requests
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_pixel_value,
   input  logic               req_line_end,
   // bar and summary records
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_result_kind,
   output logic               rsp_bar_is_white,
   output logic [12:0]        rsp_bar_width,
   output logic signed [20:0] rsp_bar_area,
   output logic [11:0]        rsp_found_left_edge,
   output logic [11:0]        rsp_found_right_edge,
   output logic [7:0]         rsp_threshold_average,
   output logic [5:0]         rsp_bar_total,
   output logic               rsp_bars_overflowed,
   output logic               rsp_edge_error,
   output logic               rsp_last_result,
   // register writes
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer: loads pixels, then walks the analysis passes
   bss_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_line_end (req_line_end),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd)
   );

   // line ram, search counters, divider and bar accumulator
   bss_datapath #(
      .LINE_PIXELS (LINE_PIXELS),
      .MAX_BARS    (MAX_BARS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_pixel_value       (req_pixel_value),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_bar_is_white      (rsp_bar_is_white),
      .rsp_bar_width         (rsp_bar_width),
      .rsp_bar_area          (rsp_bar_area),
      .rsp_found_left_edge   (rsp_found_left_edge),
      .rsp_found_right_edge  (rsp_found_right_edge),
      .rsp_threshold_average (rsp_threshold_average),
      .rsp_bar_total         (rsp_bar_total),
      .rsp_bars_overflowed   (rsp_bars_overflowed),
      .rsp_edge_error        (rsp_edge_error),
      .rsp_last_result       (rsp_last_result)
   );

   // loading and result delivery never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while a record is pending");

   // a taken summary returns the block to loading
   a_sum_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_result) |=> req_ready)
      else $error("block not idle after summary");

   // bar records always have a nonzero width
   a_bar_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_kind) |-> (rsp_bar_width != 13'd0))
      else $error("zero width bar record");

   // summary count never exceeds capacity
   a_bar_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |-> ({26'd0, rsp_bar_total} <= 32'(MAX_BARS)))
      else $error("bar count above capacity");

endmodule
